### src/ilp_pkg.sv
// Integer literal parser package: transaction structs, phase and base codes,
// character constants and small decode functions.
// No dependencies.
package ilp_pkg;

    // configuration register
    localparam int INT_BITS_W = 6;
    localparam logic [INT_BITS_W-1:0] INT_BITS_RESET = 6'd31;

    // input transaction: one character of the string
    typedef struct packed {
        logic [7:0] char_code;
        logic       last_char;
    } in_t;

    // result transaction: one per string
    typedef struct packed {
        logic [31:0] parsed_bits;
        logic        parse_failed;
    } out_t;

    // parse phase, one-hot
    typedef enum logic [4:0] {
        PH_START  = 5'b00001,
        PH_PREFIX = 5'b00010,
        PH_ZERO   = 5'b00100,
        PH_NEED   = 5'b01000,
        PH_DIGITS = 5'b10000
    } phase_t;

    // number base selected by the prefix
    typedef enum logic [1:0] {
        BASE_DEC = 2'd0,
        BASE_HEX = 2'd1,
        BASE_OCT = 2'd2,
        BASE_BIN = 2'd3
    } base_t;

    // characters
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_UNDER = 8'h5F;
    localparam logic [7:0] CH_LX    = 8'h78;
    localparam logic [7:0] CH_UX    = 8'h58;
    localparam logic [7:0] CH_LO    = 8'h6F;
    localparam logic [7:0] CH_UO    = 8'h4F;
    localparam logic [7:0] CH_LB    = 8'h62;
    localparam logic [7:0] CH_UB    = 8'h42;
    localparam logic [7:0] CH_LU    = 8'h75;
    localparam logic [7:0] CH_UU    = 8'h55;

    // digit value of a character, 16 when it is no hex digit
    function automatic logic [4:0] digit_value(input logic [7:0] c);
        logic [4:0] d;
        d = 5'd16;
        if (c >= 8'h30 && c <= 8'h39) begin
            d = 5'(c - 8'h30);
        end else if (c >= 8'h41 && c <= 8'h46) begin
            d = 5'(c - 8'h41 + 8'd10);
        end else if (c >= 8'h61 && c <= 8'h66) begin
            d = 5'(c - 8'h61 + 8'd10);
        end
        return d;
    endfunction

    // radix of a base code
    function automatic logic [4:0] base_value(input base_t b);
        logic [4:0] v;
        unique case (b)
            BASE_HEX: v = 5'd16;
            BASE_OCT: v = 5'd8;
            BASE_BIN: v = 5'd2;
            default:  v = 5'd10;
        endcase
        return v;
    endfunction

endpackage

### src/ilp_digit_acc.sv
// Digit accumulate unit: acc * base + digit with multiply and add overflow flags.
// Depends on ilp_pkg.
module ilp_digit_acc #(
    parameter int ACC_WIDTH = 32
) (
    input  logic [ACC_WIDTH-1:0] acc,
    input  ilp_pkg::base_t       base_code,
    input  logic [3:0]           digit,
    output logic [ACC_WIDTH-1:0] sum,
    output logic                 mul_ovf,
    output logic                 add_carry
);

    localparam logic [ACC_WIDTH-1:0] ACC_MASK = {ACC_WIDTH{1'b1}};
    localparam logic [ACC_WIDTH-1:0] LIM_DEC  = ACC_MASK / 10;
    localparam logic [ACC_WIDTH-1:0] LIM_HEX  = ACC_MASK >> 4;
    localparam logic [ACC_WIDTH-1:0] LIM_OCT  = ACC_MASK >> 3;
    localparam logic [ACC_WIDTH-1:0] LIM_BIN  = ACC_MASK >> 1;

    logic [ACC_WIDTH-1:0] product;
    logic [ACC_WIDTH:0]   wide_sum;

    // shift-and-add multiply by the constant radix
    always_comb begin
        unique case (base_code)
            ilp_pkg::BASE_HEX: begin
                product = acc << 4;
                mul_ovf = acc > LIM_HEX;
            end
            ilp_pkg::BASE_OCT: begin
                product = acc << 3;
                mul_ovf = acc > LIM_OCT;
            end
            ilp_pkg::BASE_BIN: begin
                product = acc << 1;
                mul_ovf = acc > LIM_BIN;
            end
            default: begin
                product = (acc << 3) + (acc << 1);
                mul_ovf = acc > LIM_DEC;
            end
        endcase
    end

    // add the digit, carry out means overflow
    assign wide_sum  = {1'b0, product} + (ACC_WIDTH+1)'(digit);
    assign sum       = wide_sum[ACC_WIDTH-1:0];
    assign add_carry = wide_sum[ACC_WIDTH];

endmodule

### src/integer_literal_parser.sv
// Integer literal parser top level: input register, per-string parse state,
// range check and result register.
// Depends on ilp_pkg and ilp_digit_acc.
//
//  channel | ports                          | transaction
//  --------+--------------------------------+-----------------------------------
//  input   | s_valid, s_ready, s_data       | one character plus last flag
//  result  | m_valid, m_ready, m_data       | parsed bits and fail flag per string
//  config  | cfg_wr_en, cfg_wr_data         | int_bits, written without wait
//
// The digit accumulate loop sets the rate: one character a cycle while no last
// character waits for the result slot. A character passes the input register before
// it steps the parse state, at the edge that loads a last character's result into m_data.
// Reset (aresetn low, synchronous) clears the parse state, both valid bits and
// sets int_bits to 31. A stalled result only holds back a last character;
// other characters keep flowing while the result waits.
module integer_literal_parser #(
    parameter int ACC_WIDTH = 32
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_valid,
    output logic                                s_ready,
    input  ilp_pkg::in_t                        s_data,
    output logic                                m_valid,
    input  logic                                m_ready,
    output ilp_pkg::out_t                       m_data,
    input  logic                                cfg_wr_en,
    input  logic [ilp_pkg::INT_BITS_W-1:0]      cfg_wr_data
);

    localparam int NB_W = ilp_pkg::INT_BITS_W + 1;

    // input register
    logic         in_valid_reg;
    ilp_pkg::in_t in_data_reg;

    // result register
    logic          m_valid_reg;
    ilp_pkg::out_t m_data_reg;

    // configuration
    logic [ilp_pkg::INT_BITS_W-1:0] int_bits_reg;

    // per-string state
    ilp_pkg::phase_t      phase_reg, phase_next;
    logic                 negative_reg, negative_next;
    ilp_pkg::base_t       base_code_reg, base_code_next;
    logic                 unsigned_reg, unsigned_next;
    logic [ACC_WIDTH-1:0] acc_reg, acc_next;
    logic                 failed_reg, failed_next;

    // step results before the end-of-string clear
    ilp_pkg::phase_t      phase_upd;
    logic                 negative_upd;
    ilp_pkg::base_t       base_code_upd;
    logic                 unsigned_upd;
    logic [ACC_WIDTH-1:0] acc_upd;
    logic                 failed_upd;

    logic                 out_free;
    logic                 step_go;
    logic [7:0]           ch;
    logic [4:0]           digit;
    logic                 digit_ok;
    logic [ACC_WIDTH-1:0] acc_sum;
    logic                 mul_ovf;
    logic                 add_carry;

    logic [NB_W-1:0]      nbits;
    logic [ACC_WIDTH:0]   res_ext;
    logic [ACC_WIDTH:0]   lim_s;
    logic [ACC_WIDTH:0]   lim_u;
    logic                 bad;
    logic [ACC_WIDTH-1:0] bits_full;
    logic [ACC_WIDTH+31:0] bits_ext;
    ilp_pkg::out_t        result;

    // handshake
    assign out_free = !m_valid_reg || m_ready;
    assign step_go  = in_valid_reg && (!in_data_reg.last_char || out_free);
    assign s_ready  = !in_valid_reg || step_go;
    assign m_valid  = m_valid_reg;
    assign m_data   = m_data_reg;

    // character decode
    assign ch       = in_data_reg.char_code;
    assign digit    = ilp_pkg::digit_value(ch);
    assign digit_ok = digit < ilp_pkg::base_value(base_code_reg);

    ilp_digit_acc #(
        .ACC_WIDTH (ACC_WIDTH)
    ) u_digit_acc (
        .acc       (acc_reg),
        .base_code (base_code_reg),
        .digit     (digit[3:0]),
        .sum       (acc_sum),
        .mul_ovf   (mul_ovf),
        .add_carry (add_carry)
    );

    // parse step for one character
    always_comb begin
        phase_upd     = phase_reg;
        negative_upd  = negative_reg;
        base_code_upd = base_code_reg;
        unsigned_upd  = unsigned_reg;
        acc_upd       = acc_reg;
        failed_upd    = failed_reg;
        if (!failed_reg) begin
            unique case (phase_reg)
                ilp_pkg::PH_START, ilp_pkg::PH_PREFIX, ilp_pkg::PH_NEED: begin
                    if (phase_reg == ilp_pkg::PH_START && ch == ilp_pkg::CH_MINUS) begin
                        negative_upd = 1'b1;
                        phase_upd    = ilp_pkg::PH_PREFIX;
                    end else if (phase_reg == ilp_pkg::PH_START
                                 && ch == ilp_pkg::CH_PLUS) begin
                        phase_upd = ilp_pkg::PH_PREFIX;
                    end else if (phase_reg != ilp_pkg::PH_NEED
                                 && ch == ilp_pkg::CH_ZERO) begin
                        acc_upd   = '0;
                        phase_upd = ilp_pkg::PH_ZERO;
                    end else if (!digit_ok) begin
                        // first digit not valid for the base
                        failed_upd = 1'b1;
                    end else begin
                        acc_upd   = ACC_WIDTH'(digit);
                        phase_upd = ilp_pkg::PH_DIGITS;
                    end
                end
                ilp_pkg::PH_ZERO, ilp_pkg::PH_DIGITS: begin
                    // prefix letter after a leading zero
                    if (phase_reg == ilp_pkg::PH_ZERO) begin
                        phase_upd = ilp_pkg::PH_DIGITS;
                        case (ch) inside
                            ilp_pkg::CH_LX, ilp_pkg::CH_UX: begin
                                base_code_upd = ilp_pkg::BASE_HEX;
                                unsigned_upd  = 1'b1;
                                phase_upd     = ilp_pkg::PH_NEED;
                            end
                            ilp_pkg::CH_LO, ilp_pkg::CH_UO: begin
                                base_code_upd = ilp_pkg::BASE_OCT;
                                unsigned_upd  = 1'b1;
                                phase_upd     = ilp_pkg::PH_NEED;
                            end
                            ilp_pkg::CH_LB, ilp_pkg::CH_UB: begin
                                base_code_upd = ilp_pkg::BASE_BIN;
                                unsigned_upd  = 1'b1;
                                phase_upd     = ilp_pkg::PH_NEED;
                            end
                            ilp_pkg::CH_LU, ilp_pkg::CH_UU: begin
                                base_code_upd = ilp_pkg::BASE_DEC;
                                unsigned_upd  = 1'b1;
                                phase_upd     = ilp_pkg::PH_NEED;
                            end
                            default: begin
                            end
                        endcase
                    end
                    // further digit, underscores skipped
                    if (phase_upd == ilp_pkg::PH_DIGITS && ch != ilp_pkg::CH_UNDER) begin
                        if (!digit_ok || mul_ovf) begin
                            failed_upd = 1'b1;
                        end else begin
                            acc_upd    = acc_sum;
                            failed_upd = add_carry;
                        end
                    end
                end
                default: begin
                    failed_upd = 1'b1;
                end
            endcase
        end
    end

    // range check and sign for the end of string
    always_comb begin
        if (int_bits_reg < ilp_pkg::INT_BITS_W'(2)) begin
            nbits = NB_W'(2);
        end else if ({1'b0, int_bits_reg} > NB_W'(ACC_WIDTH)) begin
            nbits = NB_W'(ACC_WIDTH);
        end else begin
            nbits = {1'b0, int_bits_reg};
        end
        res_ext = {1'b0, acc_upd};
        lim_s   = (ACC_WIDTH+1)'(1) << (nbits - NB_W'(1));
        lim_u   = (ACC_WIDTH+1)'(1) << nbits;
        bad     = failed_upd
                  || (phase_upd != ilp_pkg::PH_ZERO && phase_upd != ilp_pkg::PH_DIGITS);
        if (!bad) begin
            if (!unsigned_upd) begin
                bad = negative_upd ? (res_ext > lim_s) : (res_ext >= lim_s);
            end else begin
                // at full width lim_u exceeds every value
                bad = res_ext >= lim_u;
            end
        end
        if (bad) begin
            bits_full = '0;
        end else if (negative_upd) begin
            bits_full = '0 - acc_upd;
        end else begin
            bits_full = acc_upd;
        end
        bits_ext            = {32'b0, bits_full};
        result.parsed_bits  = bits_ext[31:0];
        result.parse_failed = bad;
    end

    // next state, cleared after the last character
    always_comb begin
        phase_next     = phase_reg;
        negative_next  = negative_reg;
        base_code_next = base_code_reg;
        unsigned_next  = unsigned_reg;
        acc_next       = acc_reg;
        failed_next    = failed_reg;
        if (step_go) begin
            if (in_data_reg.last_char) begin
                phase_next     = ilp_pkg::PH_START;
                negative_next  = 1'b0;
                base_code_next = ilp_pkg::BASE_DEC;
                unsigned_next  = 1'b0;
                acc_next       = '0;
                failed_next    = 1'b0;
            end else begin
                phase_next     = phase_upd;
                negative_next  = negative_upd;
                base_code_next = base_code_upd;
                unsigned_next  = unsigned_upd;
                acc_next       = acc_upd;
                failed_next    = failed_upd;
            end
        end
    end

    // parse state registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg     <= ilp_pkg::PH_START;
            negative_reg  <= 1'b0;
            base_code_reg <= ilp_pkg::BASE_DEC;
            unsigned_reg  <= 1'b0;
            acc_reg       <= '0;
            failed_reg    <= 1'b0;
        end else begin
            phase_reg     <= phase_next;
            negative_reg  <= negative_next;
            base_code_reg <= base_code_next;
            unsigned_reg  <= unsigned_next;
            acc_reg       <= acc_next;
            failed_reg    <= failed_next;
        end
    end

    // input register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_ready && s_valid) begin
            in_data_reg <= s_data;
        end
    end

    // result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (step_go && in_data_reg.last_char) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (step_go && in_data_reg.last_char) begin
            m_data_reg <= result;
        end
    end

    // configuration register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            int_bits_reg <= ilp_pkg::INT_BITS_RESET;
        end else if (cfg_wr_en) begin
            int_bits_reg <= cfg_wr_data;
        end
    end

    // a last character always leaves a result behind
    assert property (@(posedge aclk) disable iff (!aresetn)
        step_go && in_data_reg.last_char |=> m_valid_reg)
    else $error("last character did not produce a result");

    // the string state is clean after a result is formed
    assert property (@(posedge aclk) disable iff (!aresetn)
        step_go && in_data_reg.last_char |=>
            phase_reg == ilp_pkg::PH_START && !failed_reg && acc_reg == '0)
    else $error("parse state not cleared after end of string");

    // a failed parse carries a zero pattern
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg && m_data_reg.parse_failed |-> m_data_reg.parsed_bits == 32'd0)
    else $error("failed parse with nonzero bits");

    // a last character is never consumed while the result slot is full
    assert property (@(posedge aclk) disable iff (!aresetn)
        step_go && in_data_reg.last_char |-> !m_valid_reg || m_ready)
    else $error("result overwritten before it was taken");

endmodule
